### hdl/dual_stepper_line_mover_core_macros.svh
// Assertion macros shared by the stepper line mover RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DUAL_STEPPER_LINE_MOVER_CORE_MACROS_SVH
`define DUAL_STEPPER_LINE_MOVER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled at the rising clock edge.
`define DSL_ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// Next-cycle implication.
`define DSL_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`else
`define DSL_ASSERT_IMPLIES(label, clk, rst, cond, expr, msg)
`define DSL_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

### hdl/dsl_pkg.sv
// Types and constants of the stepper line mover.
// No dependencies; imported by every module of the block.
package dsl_pkg;

   localparam int COUNT_W  = 14;
   localparam int PERIOD_W = 11;

   localparam logic [COUNT_W-1:0]  COUNT_MAX        = 14'd16383;
   localparam logic [PERIOD_W-1:0] STEP_HALF_RESET  = 11'd50;
   localparam logic [PERIOD_W-1:0] DWELL_RESET      = 11'd1;

   // ASCII codes seen by the line parser
   localparam logic [7:0] CHAR_SYNC = 8'h64;  // 'd'
   localparam logic [7:0] CHAR_ONE  = 8'h31;  // '1'
   localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'

   // Item kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register indexes
   localparam logic CSR_STEP_HALF = 1'b0;
   localparam logic CSR_DWELL     = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               left_dir;
      logic               right_dir;
      logic [COUNT_W-1:0] left_count;
      logic [COUNT_W-1:0] right_count;
   } pending_move_type;

   typedef struct packed {
      logic left_step;
      logic right_step;
      logic left_direction;
      logic right_direction;
      logic motor_disable;
      logic busy_res;
      logic request_next;
   } result_type;

endpackage

### hdl/dsl_parser.sv
// Line parser: turns received characters into a pending two-axis move.
// Depends on dsl_pkg and the assertion macros header.
`include "dual_stepper_line_mover_core_macros.svh"

module dsl_parser
   import dsl_pkg::*;
#(
   parameter int COUNT_DIGITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_en,
   input  logic [7:0]       rx_byte,
   input  logic             take,
   output pending_move_type pending
);

   localparam int LINE_LEN = 3 + 2 * COUNT_DIGITS;
   localparam int POS_W    = $clog2(LINE_LEN + 1);
   localparam logic [POS_W-1:0] POS_LAST_LEFT = POS_W'(1 + COUNT_DIGITS);
   localparam logic [POS_W-1:0] POS_RIGHT_DIR = POS_W'(2 + COUNT_DIGITS);
   localparam logic [POS_W-1:0] POS_END       = POS_W'(LINE_LEN);
   localparam logic [POS_W-1:0] POS_ONE       = POS_W'(1);

   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   pending_move_type pend_ff, pend_in;
   logic left_ended_ff, left_ended_in, right_ended_ff, right_ended_in;
   logic is_digit;

   // Shift in one decimal digit, saturate at the count ceiling.
   function automatic logic [COUNT_W-1:0] add_digit(input logic [COUNT_W-1:0] cnt,
                                                    input logic [7:0] ch);
      logic [COUNT_W+3:0] wide;
      wide = ({4'b0, cnt} << 3) + ({4'b0, cnt} << 1)
           + {{COUNT_W{1'b0}}, 4'(ch - CHAR_ZERO)};
      if (wide > {4'b0, COUNT_MAX}) begin
         return COUNT_MAX;
      end
      return wide[COUNT_W-1:0];
   endfunction

   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign pos_inc  = pos_ff + POS_ONE;

   always_comb begin
      pos_in         = pos_ff;
      pend_in        = pend_ff;
      left_ended_in  = left_ended_ff;
      right_ended_in = right_ended_ff;
      if (take) begin
         pend_in.valid = 1'b0;
      end
      if (byte_en) begin
         if (rx_byte == CHAR_SYNC) begin
            pos_in         = POS_ONE;
            pend_in        = '0;
            left_ended_in  = 1'b0;
            right_ended_in = 1'b0;
         end else if (pos_ff == '0 || pos_ff >= POS_END) begin
            pos_in = '0;
         end else begin
            if (pos_ff == POS_ONE) begin
               pend_in.left_dir = (rx_byte == CHAR_ONE);
            end else if (pos_ff <= POS_LAST_LEFT) begin
               if (!left_ended_ff) begin
                  if (is_digit) begin
                     pend_in.left_count = add_digit(pend_ff.left_count, rx_byte);
                  end else begin
                     left_ended_in = 1'b1;
                  end
               end
            end else if (pos_ff == POS_RIGHT_DIR) begin
               pend_in.right_dir = (rx_byte == CHAR_ONE);
            end else begin
               if (!right_ended_ff) begin
                  if (is_digit) begin
                     pend_in.right_count = add_digit(pend_ff.right_count, rx_byte);
                  end else begin
                     right_ended_in = 1'b1;
                  end
               end
            end
            // Line complete: publish the move and wait for the next 'd'
            if (pos_inc >= POS_END) begin
               pend_in.valid = 1'b1;
               pos_in        = '0;
            end else begin
               pos_in = pos_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         pend_ff        <= '0;
         left_ended_ff  <= 1'b0;
         right_ended_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         pend_ff        <= pend_in;
         left_ended_ff  <= left_ended_in;
         right_ended_ff <= right_ended_in;
      end
   end

   assign pending = pend_ff;

   `DSL_ASSERT_IMPLIES(a_pos_in_line, clock, reset, 1'b1, pos_ff < POS_END, "line position past end")

endmodule

### hdl/dsl_motion.sv
// Move sequencer: dwell, step period timing, pulse levels and enable gating.
// Depends on dsl_pkg and the assertion macros header.
`include "dual_stepper_line_mover_core_macros.svh"

module dsl_motion
   import dsl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                tick_en,
   input  logic                limit_switch,
   input  logic [PERIOD_W-1:0] step_half_period,
   input  logic [PERIOD_W-1:0] dwell_ticks,
   input  pending_move_type    pending,
   output logic                take,
   output result_type          result
);

   logic [COUNT_W-1:0]  left_target_ff, left_target_in, right_target_ff, right_target_in;
   logic [COUNT_W-1:0]  left_done_ff, left_done_in, right_done_ff, right_done_in;
   logic                active_ff, active_in, high_ff, high_in;
   logic [PERIOD_W-1:0] phase_ff, phase_in, phase_inc, dwell_ff, dwell_in;
   logic [1:0]          dir_ff, dir_in;
   logic                disable_ff, disable_in;
   logic                start, run, ended;
   logic [COUNT_W-1:0]  eff_lt, eff_rt, eff_ld, eff_rd;

   assign phase_inc = phase_ff + PERIOD_W'(1);

   always_comb begin
      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      left_done_in    = left_done_ff;
      right_done_in   = right_done_ff;
      active_in       = active_ff;
      high_in         = high_ff;
      phase_in        = phase_ff;
      dwell_in        = dwell_ff;
      dir_in          = dir_ff;
      disable_in      = disable_ff;
      start           = 1'b0;
      run             = 1'b0;
      ended           = 1'b0;

      if (tick_en) begin
         if (active_ff) begin
            // Zero half period wraps through zero and acts as one tick
            if (phase_inc >= step_half_period || phase_inc == '0) begin
               if (high_ff) begin
                  high_in  = 1'b0;
                  phase_in = '0;
               end else begin
                  run = 1'b1;
               end
            end else begin
               phase_in = phase_inc;
            end
         end else if (dwell_ff != '0) begin
            dwell_in = dwell_ff - PERIOD_W'(1);
         end else if (pending.valid) begin
            start           = 1'b1;
            run             = 1'b1;
            left_target_in  = pending.left_count;
            right_target_in = pending.right_count;
            dir_in          = {pending.right_dir, pending.left_dir};
            active_in       = 1'b1;
         end
      end

      eff_lt = start ? pending.left_count  : left_target_ff;
      eff_rt = start ? pending.right_count : right_target_ff;
      eff_ld = start ? '0 : left_done_ff;
      eff_rd = start ? '0 : right_done_ff;

      if (start) begin
         left_done_in  = '0;
         right_done_in = '0;
      end

      // Begin the next step period, or end the move
      if (run) begin
         phase_in = '0;
         if (eff_ld == eff_lt && eff_rd == eff_rt) begin
            active_in = 1'b0;
            high_in   = 1'b0;
            dwell_in  = dwell_ticks;
            ended     = 1'b1;
         end else begin
            disable_in    = !limit_switch && !dir_in[0];
            left_done_in  = eff_ld + COUNT_W'(eff_ld < eff_lt);
            right_done_in = eff_rd + COUNT_W'(eff_rd < eff_rt);
            high_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_target_ff  <= '0;
         right_target_ff <= '0;
         left_done_ff    <= '0;
         right_done_ff   <= '0;
         active_ff       <= 1'b0;
         high_ff         <= 1'b0;
         phase_ff        <= '0;
         dwell_ff        <= '0;
         dir_ff          <= '0;
         disable_ff      <= 1'b0;
      end else begin
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         left_done_ff    <= left_done_in;
         right_done_ff   <= right_done_in;
         active_ff       <= active_in;
         high_ff         <= high_in;
         phase_ff        <= phase_in;
         dwell_ff        <= dwell_in;
         dir_ff          <= dir_in;
         disable_ff      <= disable_in;
      end
   end

   assign take = start;

   // The axis with the larger step count sets the period; both step on a tie
   always_comb begin
      result.left_step       = active_in && high_in && (left_done_in >= right_done_in);
      result.right_step      = active_in && high_in && (right_done_in >= left_done_in);
      result.left_direction  = dir_in[0];
      result.right_direction = dir_in[1];
      result.motor_disable   = disable_in;
      result.busy_res        = active_in || (dwell_in != '0);
      result.request_next    = ended;
   end

   `DSL_ASSERT_IMPLIES(a_left_done_bound, clock, reset, 1'b1, left_done_ff <= left_target_ff, "left step count overran target")
   `DSL_ASSERT_IMPLIES(a_right_done_bound, clock, reset, 1'b1, right_done_ff <= right_target_ff, "right step count overran target")
   `DSL_ASSERT_IMPLIES(a_high_needs_move, clock, reset, high_ff, active_ff, "pulse phase high outside a move")
   `DSL_ASSERT_NEXT(a_end_goes_idle, clock, reset, ended, !active_ff && !high_ff, "move still active after its end")

endmodule

### hdl/dual_stepper_line_mover_core.sv
// Top level of the two-axis stepper line mover: handshakes, settings, result register.
// Depends on dsl_pkg, dsl_parser, dsl_motion and the assertion macros header.
//
// The block takes one item per clock: either a received character (req_command = 0),
// which feeds the line parser, or one timer tick (req_command = 1), which advances
// the move sequencer. Lines have the form d a <digits> b <digits>, COUNT_DIGITS digits
// per count; 'd' always restarts a line and discards a move still waiting to start.
// Each accepted item yields exactly one result in the next cycle, holding the step,
// direction, disable and busy levels after the update, plus a one-result
// request_next pulse on the tick that ends a move. All state updates in the cycle of
// the transfer, so the sustained rate is one item per cycle; the single result
// register lets a new item in while the previous result is being taken, and the
// input stalls only when that register is full and rsp_ready is low. Settings
// (index 0: step half period, index 1: dwell ticks) are taken every cycle and are
// meant to be written while the block is idle. No clearing pass after reset.
`include "dual_stepper_line_mover_core_macros.svh"

module dual_stepper_line_mover_core
   import dsl_pkg::*;
#(
   parameter int COUNT_DIGITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   // input items
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_limit_switch,
   // results
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_left_step,
   output logic                rsp_right_step,
   output logic                rsp_left_direction,
   output logic                rsp_right_direction,
   output logic                rsp_motor_disable,
   output logic                rsp_busy_res,
   output logic                rsp_request_next,
   // settings
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [PERIOD_W-1:0] csr_wdata
);

   logic                accept;
   logic                byte_en, tick_en, take;
   pending_move_type    pending;
   result_type          result, rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0] half_ff, half_in, dwell_ff, dwell_in;

   // Accept when the result register is empty or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign byte_en   = accept && (req_command == CMD_BYTE);
   assign tick_en   = accept && (req_command == CMD_TICK);

   // Settings: always ready, one write per transfer
   assign csr_ready = 1'b1;

   always_comb begin
      half_in  = half_ff;
      dwell_in = dwell_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_HALF: half_in  = csr_wdata;
            CSR_DWELL:     dwell_in = csr_wdata;
            default:       half_in  = half_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= STEP_HALF_RESET;
         dwell_ff <= DWELL_RESET;
      end else begin
         half_ff  <= half_in;
         dwell_ff <= dwell_in;
      end
   end

   dsl_parser #(
      .COUNT_DIGITS(COUNT_DIGITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .byte_en (byte_en),
      .rx_byte (req_rx_byte),
      .take    (take),
      .pending (pending)
   );

   dsl_motion u_motion (
      .clock            (clock),
      .reset            (reset),
      .tick_en          (tick_en),
      .limit_switch     (req_limit_switch),
      .step_half_period (half_ff),
      .dwell_ticks      (dwell_ff),
      .pending          (pending),
      .take             (take),
      .result           (result)
   );

   // Result register: load on input transfer, drop on output transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_step       = rsp_ff.left_step;
   assign rsp_right_step      = rsp_ff.right_step;
   assign rsp_left_direction  = rsp_ff.left_direction;
   assign rsp_right_direction = rsp_ff.right_direction;
   assign rsp_motor_disable   = rsp_ff.motor_disable;
   assign rsp_busy_res        = rsp_ff.busy_res;
   assign rsp_request_next    = rsp_ff.request_next;

   `DSL_ASSERT_IMPLIES(a_step_means_busy, clock, reset, rsp_valid_ff && (rsp_ff.left_step || rsp_ff.right_step), rsp_ff.busy_res, "step pulse while not busy")
   `DSL_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff, "transfer left no result")

endmodule
